>>> src/task_scheduler_rr_priority_assert.svh
// ----------------------------------------------------------------------------
// Task scheduler assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef TASK_SCHEDULER_RR_PRIORITY_ASSERT_SVH
`define TASK_SCHEDULER_RR_PRIORITY_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TSRR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("task scheduler assertion failed");
// Next-cycle implication.
`define TSRR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("task scheduler assertion failed");
`else
`define TSRR_ASSERT_NOW(label, clk, rst, ante, cons)
`define TSRR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/tsrr_pkg.sv
// ----------------------------------------------------------------------------
// Task scheduler package
// Shared constants, field positions and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tsrr_pkg;

  localparam int DEF_NUM_TASKS      = 8;
  localparam int DEF_NUM_PRIORITIES = 8;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int COUNT_W     = 4;
  localparam int SLOT_W      = 3;
  localparam int PRI_REQ_W   = 3;
  localparam int TASK_OUT_W  = 3;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 8;

  // Field positions inside the input tdata word.
  localparam int SLOT_LSB  = 0;
  localparam int READY_BIT = 3;
  localparam int PRI_LSB   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

  localparam logic MODE_RR   = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  // What one pass of the slot scanner evaluates.
  typedef enum logic [1:0] {
    SCAN_RR,
    SCAN_MIN,
    SCAN_MATCH
  } scan_kind_t;

  typedef struct packed {
    logic       wr;
    logic       ld_rr;
    logic       ld_lp;
    logic       reduce;
    logic       start;
    scan_kind_t kind;
    logic       step;
    logic       commit;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic x_ge_n;
    logic rem_zero;
    logic min_found;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> src/tsrr_datapath.sv
// ----------------------------------------------------------------------------
// Task scheduler datapath
// Slot table, last-pick memory, start reduction, slot scanner and result register.
// ----------------------------------------------------------------------------
`include "task_scheduler_rr_priority_assert.svh"

module tsrr_datapath #(
  parameter int NUM_TASKS      = tsrr_pkg::DEF_NUM_TASKS,
  parameter int NUM_PRIORITIES = tsrr_pkg::DEF_NUM_PRIORITIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tsrr_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [tsrr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [tsrr_pkg::IN_DATA_W-1:0]   in_data,
  input  logic                             out_ready,
  input  tsrr_pkg::dp_cmd_t                cmd,
  output tsrr_pkg::dp_stat_t               stat,
  output logic                             out_valid,
  output logic [tsrr_pkg::TASK_OUT_W-1:0]  out_task
);

  localparam int TW = $clog2(NUM_TASKS);
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam int PW = $clog2(NUM_PRIORITIES);

  logic                          mode;
  logic [tsrr_pkg::COUNT_W-1:0]  count;
  logic [NUM_TASKS-1:0]          task_ready;
  logic [PW-1:0]                 prio_mem [NUM_TASKS];
  logic [TW-1:0]                 lp_mem [NUM_PRIORITIES];
  logic [NUM_PRIORITIES-1:0]     lp_vld;
  logic [TW-1:0]                 cur;
  logic [CW-1:0]                 x;
  logic [TW-1:0]                 idx;
  logic [CW-1:0]                 rem;
  tsrr_pkg::scan_kind_t          kind;
  logic                          s_valid;
  logic [TW-1:0]                 s_idx;
  logic                          s_rdy;
  logic [PW-1:0]                 pri_q;
  logic [PW-1:0]                 best;
  logic                          min_found;
  logic                          hit_found;
  logic [TW-1:0]                 hit;
  logic [TW-1:0]                 lp_q;
  logic                          lp_v_q;

  logic [CW-1:0]  n;
  logic [7:0]     count_ext;
  logic [6:0]     slot_ext;
  logic           slot_ok;
  logic [TW-1:0]  slot_idx;
  logic [8:0]     pri_ext;
  logic [PW-1:0]  pri_clamped;
  logic [TW-1:0]  idx_next;
  logic [TW-1:0]  pick;
  logic [6:0]     pick_ext;
  logic           lp_we;

  // Slots in use: a count of zero acts as one, a count above the table as the table.
  assign count_ext = 8'(count);
  always_comb begin
    if (count == '0) begin
      n = CW'(1);
    end else if (count_ext > 8'(NUM_TASKS)) begin
      n = CW'(NUM_TASKS);
    end else begin
      n = CW'(count);
    end
  end

  assign slot_ext    = 7'(in_data[tsrr_pkg::SLOT_LSB +: tsrr_pkg::SLOT_W]);
  assign slot_ok     = slot_ext < 7'(NUM_TASKS);
  assign slot_idx    = slot_ext[TW-1:0];
  assign pri_ext     = 9'(in_data[tsrr_pkg::PRI_LSB +: tsrr_pkg::PRI_REQ_W]);
  assign pri_clamped = (pri_ext >= 9'(NUM_PRIORITIES)) ? PW'(NUM_PRIORITIES - 1)
                                                       : pri_ext[PW-1:0];

  assign idx_next = ((CW'(idx) + CW'(1)) == n) ? '0 : idx + TW'(1);
  assign pick     = hit_found ? hit : '0;
  assign pick_ext = 7'(pick);
  assign lp_we    = cmd.commit && (kind == tsrr_pkg::SCAN_MATCH) && hit_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= tsrr_pkg::MODE_RR;
      count      <= tsrr_pkg::COUNT_RESET;
      task_ready <= '0;
      lp_vld     <= '0;
      cur        <= '0;
      kind       <= tsrr_pkg::SCAN_RR;
      s_valid    <= 1'b0;
      min_found  <= 1'b0;
      hit_found  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_addr == tsrr_pkg::REG_MODE)) begin
        mode <= cfg_wdata[0];
      end
      if (cfg_wr_en && (cfg_addr == tsrr_pkg::REG_COUNT)) begin
        count <= cfg_wdata[tsrr_pkg::COUNT_W-1:0];
      end
      if (cmd.wr && slot_ok) begin
        task_ready[slot_idx] <= in_data[tsrr_pkg::READY_BIT];
      end

      s_valid <= cmd.step;

      // Evaluation stage: one slot per cycle behind the address stage.
      if (s_valid) begin
        case (kind)
          tsrr_pkg::SCAN_RR: begin
            if (!hit_found && s_rdy && (s_idx != '0)) begin
              hit_found <= 1'b1;
            end
          end
          tsrr_pkg::SCAN_MIN: begin
            if (s_rdy && (!min_found || (pri_q < best))) begin
              min_found <= 1'b1;
            end
          end
          tsrr_pkg::SCAN_MATCH: begin
            if (!hit_found && s_rdy && (pri_q == best)) begin
              hit_found <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      if (cmd.start) begin
        kind      <= cmd.kind;
        hit_found <= 1'b0;
        if (cmd.kind == tsrr_pkg::SCAN_MIN) begin
          min_found <= 1'b0;
        end
      end

      if (cmd.commit) begin
        cur       <= pick;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (lp_we) begin
        lp_vld[best] <= 1'b1;
      end
    end
  end

  // Payload registers and memories.
  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ok) begin
      prio_mem[slot_idx] <= pri_clamped;
    end
    pri_q <= prio_mem[idx];

    if (lp_we) begin
      lp_mem[best] <= hit;
    end
    lp_q   <= lp_mem[best];
    lp_v_q <= lp_vld[best];

    if (cmd.ld_rr) begin
      x <= CW'(cur) + CW'(1);
    end else if (cmd.ld_lp) begin
      x <= (lp_v_q ? CW'(lp_q) : CW'(0)) + CW'(1);
    end else if (cmd.reduce) begin
      x <= x - n;
    end

    if (cmd.start) begin
      if (cmd.kind == tsrr_pkg::SCAN_MIN) begin
        idx <= TW'(1);
        rem <= n - CW'(1);
      end else begin
        idx <= x[TW-1:0];
        rem <= n;
      end
    end else if (cmd.step) begin
      idx <= idx_next;
      rem <= rem - CW'(1);
    end

    s_idx <= idx;
    s_rdy <= task_ready[idx];

    if (s_valid) begin
      case (kind)
        tsrr_pkg::SCAN_RR: begin
          if (!hit_found && s_rdy && (s_idx != '0)) begin
            hit <= s_idx;
          end
        end
        tsrr_pkg::SCAN_MIN: begin
          if (s_rdy && (!min_found || (pri_q < best))) begin
            best <= pri_q;
          end
        end
        tsrr_pkg::SCAN_MATCH: begin
          if (!hit_found && s_rdy && (pri_q == best)) begin
            hit <= s_idx;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.commit) begin
      out_task <= pick_ext[tsrr_pkg::TASK_OUT_W-1:0];
    end
  end

  assign stat.mode      = mode;
  assign stat.x_ge_n    = x >= n;
  assign stat.rem_zero  = rem == '0;
  assign stat.min_found = min_found;
  assign stat.out_busy  = out_valid && !out_ready;

  // A scan over all slots starts inside the slots in use once the start is reduced.
  `TSRR_ASSERT_NXT(a_start_in_range, clk, rst, cmd.start && (cmd.kind != tsrr_pkg::SCAN_MIN), CW'(idx) < n)
  // The minimum search covers slots 1 and up only.
  `TSRR_ASSERT_NOW(a_min_skips_idle, clk, rst, s_valid && (kind == tsrr_pkg::SCAN_MIN), s_idx != '0)
  // A priority found in the first pass is always found again in the second.
  `TSRR_ASSERT_NOW(a_match_found, clk, rst, cmd.commit && (kind == tsrr_pkg::SCAN_MATCH), hit_found)
  // The task put in charge is the idle slot or a ready one.
  `TSRR_ASSERT_NXT(a_pick_ready, clk, rst, cmd.commit, (cur == '0) || task_ready[cur])

endmodule

>>> src/tsrr_ctrl.sv
// ----------------------------------------------------------------------------
// Task scheduler controller
// Sequences slot writes, start reduction, scans and the result commit.
// ----------------------------------------------------------------------------
module tsrr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_sched,
  output logic               in_ready,
  input  tsrr_pkg::dp_stat_t stat,
  output tsrr_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RR_LOAD,
    ST_MIN_START,
    ST_MIN_SCAN,
    ST_MIN_DRAIN,
    ST_LP_READ,
    ST_LP_LOAD,
    ST_REDUCE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   fire;

  assign in_ready = (state == ST_IDLE);
  assign fire     = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.kind   = tsrr_pkg::SCAN_RR;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.wr = fire && (in_sched == tsrr_pkg::CMD_WRITE);
        if (fire && (in_sched == tsrr_pkg::CMD_SCHED)) begin
          state_next = (stat.mode == tsrr_pkg::MODE_PRIO) ? ST_MIN_START : ST_RR_LOAD;
        end
      end
      ST_RR_LOAD: begin
        cmd.ld_rr  = 1'b1;
        state_next = ST_REDUCE;
      end
      ST_MIN_START: begin
        cmd.start  = 1'b1;
        cmd.kind   = tsrr_pkg::SCAN_MIN;
        state_next = ST_MIN_SCAN;
      end
      ST_MIN_SCAN: begin
        cmd.step = !stat.rem_zero;
        if (stat.rem_zero) begin
          state_next = ST_MIN_DRAIN;
        end
      end
      ST_MIN_DRAIN: begin
        state_next = ST_LP_READ;
      end
      ST_LP_READ: begin
        state_next = stat.min_found ? ST_LP_LOAD : ST_EMIT;
      end
      ST_LP_LOAD: begin
        cmd.ld_lp  = 1'b1;
        state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd.reduce = stat.x_ge_n;
        cmd.start  = !stat.x_ge_n;
        cmd.kind   = (stat.mode == tsrr_pkg::MODE_PRIO) ? tsrr_pkg::SCAN_MATCH
                                                        : tsrr_pkg::SCAN_RR;
        if (!stat.x_ge_n) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = !stat.rem_zero;
        if (stat.rem_zero) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.commit = !stat.out_busy;
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/task_scheduler_rr_priority.sv
// A write item takes effect at its acceptance edge and gives no result.
// Round-robin schedule: load the slot after the current task, subtract the slot count n
// until the start is below n, scan from there; the slot scanner checks one slot a cycle.
// Priority: minimum search; if a task is ready, last-pick load, wraps, match scan; then emit.
// Throughput: the next item is taken the cycle after the commit, which waits for the output.
// Reset (rst, synchronous) clears the ready bits, last-pick marks, current task and mode.
// ----------------------------------------------------------------------------
// Round-robin / priority task scheduler
// Keeps a table of task slots and picks the next running task on request.
// ----------------------------------------------------------------------------
module task_scheduler_rr_priority #(
  parameter int NUM_TASKS      = tsrr_pkg::DEF_NUM_TASKS,
  parameter int NUM_PRIORITIES = tsrr_pkg::DEF_NUM_PRIORITIES
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration writes: index 0 is scheduler_mode, index 1 is task_count.
  input  logic                             cfg_wr_en,
  input  logic [tsrr_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [tsrr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input items.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] slot, [3] ready_req, [6:4] priority_req, [7] zero
  input  logic [tsrr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] cmd: 0 writes a slot, 1 schedules the next task
  input  logic                             s_axis_tuser,
  // Result items.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] running_task, [7:3] zero
  output logic [tsrr_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // The controller walks each schedule request through its phases and drives
  // the datapath by command; the datapath reports back only through status.
  // A result sits in the output register until its transfer, so a new item
  // can be taken while the previous result is still waiting; only the commit
  // of the next result waits for that register to free up.

  tsrr_pkg::dp_cmd_t  cmd;
  tsrr_pkg::dp_stat_t stat;
  logic [tsrr_pkg::TASK_OUT_W-1:0] out_task;

  tsrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_sched (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsrr_datapath #(
    .NUM_TASKS      (NUM_TASKS),
    .NUM_PRIORITIES (NUM_PRIORITIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_task  (out_task)
  );

  // The running task sits in the low bits; the rest of the byte is zero.
  assign m_axis_tdata = tsrr_pkg::OUT_DATA_W'(out_task);

endmodule

>>> tb/sv/tsrr_pick_checker.sv
// ----------------------------------------------------------------------------
// Task scheduler pick checker
// Watches the configuration port and both streams, keeps its own copy of the
// task table, predicts each running-task pick and compares it on arrival.
// ----------------------------------------------------------------------------
module tsrr_pick_checker
  import tsrr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = DEF_NUM_TASKS;
  localparam int NP = DEF_NUM_PRIORITIES;

  // Shadow copy of the scheduler state.
  logic                  sched_mode;
  logic [COUNT_W-1:0]    sched_count;
  logic                  task_rdy  [NT];
  logic [PRI_REQ_W-1:0]  task_pri  [NT];
  logic [TASK_OUT_W-1:0] last_pick [NP];
  logic [TASK_OUT_W-1:0] running;

  logic [TASK_OUT_W-1:0] expected_picks [$];

  initial mismatches = 0;
  initial pending = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] pick check: %s", $time, what);
    mismatches++;
  endtask

  // Works out the next running task and updates the shadow state as the
  // block does for one schedule request.
  function automatic logic [TASK_OUT_W-1:0] next_running_task();
    int n, k, idx, best, start;
    bit found;
    logic [TASK_OUT_W-1:0] pick;
    n = (sched_count == 0) ? 1 : ((sched_count > NT) ? NT : int'(sched_count));
    pick = '0;
    found = 1'b0;
    if (sched_mode == MODE_RR) begin
      // Next ready slot after the current one, idle slot excluded.
      for (k = 1; k <= n; k++) begin
        idx = (int'(running) + k) % n;
        if (!found && idx != 0 && task_rdy[idx]) begin
          pick = TASK_OUT_W'(idx);
          found = 1'b1;
        end
      end
    end else begin
      // Most urgent priority among ready slots 1..n-1.
      best = 0;
      for (k = 1; k < n; k++) begin
        if (task_rdy[k] && (!found || int'(task_pri[k]) < best)) begin
          best = task_pri[k];
          found = 1'b1;
        end
      end
      if (found) begin
        // Rotate within that priority; the idle slot may take part here.
        start = (int'(last_pick[best]) + 1) % n;
        found = 1'b0;
        for (k = 0; k < n; k++) begin
          idx = (start + k) % n;
          if (!found && task_rdy[idx] && int'(task_pri[idx]) == best) begin
            pick = TASK_OUT_W'(idx);
            last_pick[best] = TASK_OUT_W'(idx);
            found = 1'b1;
          end
        end
      end
    end
    running = pick;
    return pick;
  endfunction

  always @(posedge clk) begin : watch
    int i;
    logic [SLOT_W-1:0] wslot;
    logic [TASK_OUT_W-1:0] want;
    logic [TASK_OUT_W-1:0] got;
    if (rst) begin
      sched_mode = MODE_RR;
      sched_count = COUNT_RESET;
      for (i = 0; i < NT; i++) begin
        task_rdy[i] = 1'b0;
        task_pri[i] = '0;
      end
      for (i = 0; i < NP; i++) last_pick[i] = '0;
      running = '0;
      expected_picks.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == REG_MODE) sched_mode = cfg_wdata[0];
        else if (cfg_addr == REG_COUNT) sched_count = cfg_wdata[COUNT_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_WRITE) begin
          // Every 3-bit slot and priority is inside the table here.
          wslot = s_axis_tdata[SLOT_LSB +: SLOT_W];
          task_rdy[wslot] = s_axis_tdata[READY_BIT];
          task_pri[wslot] = s_axis_tdata[PRI_LSB +: PRI_REQ_W];
        end else begin
          expected_picks.push_back(next_running_task());
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[TASK_OUT_W-1:0];
        if (expected_picks.size() == 0) begin
          report_mismatch($sformatf("running_task %0d with no request waiting", got));
        end else begin
          want = expected_picks.pop_front();
          if (got !== want)
            report_mismatch($sformatf("running_task %0d, predicted %0d", got, want));
          if (m_axis_tdata[OUT_DATA_W-1:TASK_OUT_W] !== '0)
            report_mismatch($sformatf("pad bits of tdata %h not zero", m_axis_tdata));
        end
      end
    end
    pending <= expected_picks.size();
  end

endmodule

>>> tb/sv/task_scheduler_rr_priority_test.sv
// ----------------------------------------------------------------------------
// Task scheduler testbench
// Drives slot writes and schedule requests with random flow control on both
// streams, across several mode and slot-count settings; the pick checker
// predicts every running task and this top gives the verdict.
// ----------------------------------------------------------------------------
module task_scheduler_rr_priority_test;
  import tsrr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to wait after the last result before touching the configuration:
  // a priority pick over eight slots, wrap included, fits well within them.
  localparam int SETTLE_CYCLES = 40;
  localparam int SINK_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 102;
  localparam int HOLD_PHASE    = 3;
  localparam int DRAIN_PHASE   = 6;

  // Settings for the random phases; the slot count covers zero, one, the
  // table size and values past it.
  localparam logic         PHASE_MODE  [NUM_PHASES] = '{
    MODE_RR, MODE_PRIO, MODE_PRIO, MODE_RR, MODE_PRIO, MODE_RR,
    MODE_PRIO, MODE_PRIO, MODE_RR, MODE_PRIO, MODE_RR, MODE_PRIO};
  localparam int           PHASE_COUNT [NUM_PHASES] = '{
    8, 8, 1, 15, 0, 3, 2, 9, 5, 4, 8, 6};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = CMD_WRITE;

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int mismatches;
  int pending;
  int cycle_count = 0;

  // The sender asks the receiver for a long hold-off by raising this count;
  // the receiver counts the holds it has served.
  int  sink_holds_asked = 0;
  int  sink_holds_done  = 0;
  // When set, the sender offers items back to back.
  bit  steady_sender = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task_scheduler_rr_priority dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tsrr_pick_checker pick_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // Gap length shared by both sides: mostly none or short, now and then long.
  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one item and returns right after the edge of its transfer. The
  // valid is left high so that a following item can go out back to back;
  // the idle gap after it lowers valid only when there is a gap.
  task automatic offer(input logic cmd, input logic [SLOT_W-1:0] slot,
                       input logic rdy, input logic [PRI_REQ_W-1:0] pri);
    logic [IN_DATA_W-1:0] word;
    int gap;
    word = '0;
    word[SLOT_LSB +: SLOT_W]    = slot;
    word[READY_BIT]             = rdy;
    word[PRI_LSB +: PRI_REQ_W]  = pri;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    gap = steady_sender ? 0 : random_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A schedule request; the slot fields are don't-care and get random bits.
  task automatic request_pick();
    offer(CMD_SCHED, SLOT_W'($urandom), 1'($urandom), PRI_REQ_W'($urandom));
  endtask

  // Stops offering and waits until every predicted pick has been taken,
  // then lets a last scan run out. The extra edge first makes sure the
  // checker has seen the final transfer.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are written only once the block is idle.
  task automatic set_config(input logic mode, input int count);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_addr  <= REG_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: bursts of acceptance broken by random stalls, sometimes a long
  // run with no stall, and a long hold-off whenever the sender asks for one.
  initial begin : sink
    int burst;
    int gap;
    forever begin
      if (sink_holds_done != sink_holds_asked) begin
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
        sink_holds_done++;
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 16);
        m_axis_tready <= 1'b1;
        repeat (burst) @(posedge clk);
        gap = random_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("task_scheduler_rr_priority verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int i;
    int hi;
    logic [SLOT_W-1:0] slot;
    logic rdy;
    logic [PRI_REQ_W-1:0] pri;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, starting from the reset settings: round robin over all
    // eight slots.
    request_pick();                     // nothing ready: the idle task
    offer(CMD_WRITE, 3'd0, 1'b1, 3'd0); // a ready idle slot is skipped
    request_pick();
    offer(CMD_WRITE, 3'd7, 1'b1, 3'd7); // extremes of slot and priority
    offer(CMD_WRITE, 3'd3, 1'b1, 3'd0);
    request_pick();
    request_pick();
    request_pick();                     // wraps back to slot 3
    offer(CMD_WRITE, 3'd3, 1'b0, 3'd0);
    request_pick();
    request_pick();                     // the only candidate is picked again

    // Priority mode: the most urgent level rotates and includes the ready
    // idle slot once the scan wraps past the end.
    set_config(MODE_PRIO, 8);
    offer(CMD_WRITE, 3'd5, 1'b1, 3'd0);
    request_pick();
    request_pick();
    offer(CMD_WRITE, 3'd5, 1'b0, 3'd0);
    offer(CMD_WRITE, 3'd7, 1'b0, 3'd0);
    offer(CMD_WRITE, 3'd0, 1'b0, 3'd0);
    request_pick();                     // nothing ready in priority mode

    // Slot count of zero acts as one, a count past the table acts as eight.
    set_config(MODE_RR, 0);
    offer(CMD_WRITE, 3'd1, 1'b1, 3'd3);
    request_pick();
    set_config(MODE_RR, 15);
    request_pick();
    offer(CMD_WRITE, 3'd7, 1'b1, 3'd5);
    request_pick();
    // The current task is now beyond the new count, so the scan wraps.
    set_config(MODE_RR, 4);
    request_pick();

    // Random phases. Writes favor slots in use and a few priority levels
    // so that ties and rotation within a level come up often.
    for (p = 0; p < NUM_PHASES; p++) begin
      set_config(PHASE_MODE[p], PHASE_COUNT[p]);
      steady_sender = (p % 4 == 1);
      hi = (PHASE_COUNT[p] == 0) ? 0 :
           ((PHASE_COUNT[p] > DEF_NUM_TASKS) ? DEF_NUM_TASKS - 1 : PHASE_COUNT[p] - 1);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // The receiver holds off while items keep coming, so the block backs up.
        if (p == HOLD_PHASE && i == 0) sink_holds_asked++;
        // Midway through one phase the sender waits for every result.
        if (p == DRAIN_PHASE && i == PHASE_ITEMS / 2) drain();
        if ($urandom_range(0, 99) < 40) begin
          request_pick();
        end else begin
          slot = ($urandom_range(0, 99) < 70) ? SLOT_W'($urandom_range(0, hi))
                                              : SLOT_W'($urandom);
          rdy  = ($urandom_range(0, 99) < 65);
          pri  = ($urandom_range(0, 99) < 70) ? PRI_REQ_W'($urandom_range(0, 2))
                                              : PRI_REQ_W'($urandom);
          offer(CMD_WRITE, slot, rdy, pri);
        end
      end
    end
    steady_sender = 1'b0;

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("task_scheduler_rr_priority verification clean");
    end else begin
      $display("task_scheduler_rr_priority verification failed");
    end
    $finish;
  end

endmodule
